@@ hdl/mssa_pkg.sv @@
// Shared types, constants and codes of the MCMC step-size autotuner.
package mssa_pkg;

    // Default depth of the history ring
    localparam int HIST_DEPTH_DEF = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACC_MIN    = 3'd0;
    localparam logic [2:0] CFG_ACC_MAX    = 3'd1;
    localparam logic [2:0] CFG_MAX_DEV    = 3'd2;
    localparam logic [2:0] CFG_MAX_DEV_EN = 3'd3;
    localparam logic [2:0] CFG_INIT_DEV   = 3'd4;
    localparam logic [2:0] CFG_MIN_TRIALS = 3'd5;

    // Register values after reset
    localparam logic [16:0] ACC_MIN_RST    = 17'd19661;
    localparam logic [16:0] ACC_MAX_RST    = 17'd45875;
    localparam logic [31:0] MAX_DEV_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] INIT_DEV_RST   = 32'd65536;
    localparam logic [19:0] MIN_TRIALS_RST = 20'd100;

    // Result outcome codes
    localparam logic [2:0] OUT_TRIAL = 3'd0;
    localparam logic [2:0] OUT_FEW   = 3'd1;
    localparam logic [2:0] OUT_KEPT  = 3'd2;
    localparam logic [2:0] OUT_BLIND = 3'd3;
    localparam logic [2:0] OUT_FIT   = 3'd4;
    localparam logic [2:0] OUT_FITBL = 3'd5;

    // Operations of the shared serial multiplier
    typedef enum logic [2:0] {
        MOP_BLIND = 3'd0,
        MOP_NSXX  = 3'd1,
        MOP_SX2   = 3'd2,
        MOP_DEN   = 3'd3,
        MOP_NSXY  = 3'd4,
        MOP_SXSY  = 3'd5,
        MOP_T1    = 3'd6,
        MOP_T2    = 3'd7
    } mop_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       trial_upd;
        logic       r_load;
        logic       rate_zero;
        logic       div_start;
        logic       div_fit;
        logic       rec;
        logic       sum_clr;
        logic       rd_en;
        logic       mul_start;
        mop_t       mul_op;
        logic       out_load;
        logic [2:0] out_code;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic few;
        logic trial_zero;
        logic div_done;
        logic mul_done;
        logic inwin;
        logic fit_due;
        logic d_zero;
        logic num_neg;
    } sts_t;

endpackage

@@ hdl/mssa_mul.sv @@
// Shift-and-add serial multiplier, product truncated to 128 bits.
module mssa_mul
    import mssa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] p
);

    logic         run_reg;
    logic         run_next;
    logic [127:0] acc_reg;
    logic [127:0] a_reg;
    logic [63:0]  b_reg;

    // Finished once every multiplier bit has been consumed
    assign done = run_reg && (b_reg == 64'd0);
    assign p    = acc_reg;

    always_comb
    begin
        run_next = run_reg;
        if (start)
        begin
            run_next = 1'b1;
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    // One multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= 128'd0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (run_reg && (b_reg != 64'd0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[126:0], 1'b0};
            b_reg <= {1'b0, b_reg[63:1]};
        end
    end

endmodule

@@ hdl/mssa_div.sv @@
// Restoring serial divider, 128-bit dividend, quotient saturated to 32 bits.
module mssa_div
    import mssa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] dividend,
    input  logic [63:0]  divisor,
    output logic         done,
    output logic [31:0]  q
);

    logic         run_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] num_reg;
    logic [63:0]  dvs_reg;
    logic [63:0]  rem_reg;
    logic [31:0]  q_reg;
    logic         big_reg;
    logic [64:0]  rs;
    logic [64:0]  diff;
    logic         ge;

    // One quotient bit per cycle
    assign rs   = {rem_reg, num_reg[127]};
    assign ge   = rs >= {1'b0, dvs_reg};
    assign diff = rs - {1'b0, dvs_reg};

    assign done = done_reg;
    assign q    = big_reg ? 32'hFFFF_FFFF : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 7'h7F;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= 64'd0;
            q_reg   <= 32'd0;
            big_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : rs[63:0];
            // Quotient bits at or above bit 32 only mark saturation
            if (cnt_reg[6:5] != 2'd0)
            begin
                big_reg <= big_reg | ge;
            end
            else
            begin
                q_reg <= {q_reg[30:0], ge};
            end
        end
    end

endmodule

@@ hdl/mssa_dp.sv @@
// Datapath: counters, history ring, fit sums, shared multiplier and divider.
module mssa_dp
    import mssa_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int AW = $clog2(HIST_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic [AW-1:0] rd_addr,
    output sts_t          sts,
    input  logic          accepted,
    input  logic [15:0]   random_fraction,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output logic [31:0]   current_dev,
    output logic [16:0]   acc_rate,
    output logic [2:0]    outcome
);

    localparam int CW   = $clog2(HIST_DEPTH + 1);
    localparam int SXW  = 17 + CW;
    localparam int SYW  = 32 + CW;
    localparam int SXXW = 34 + CW;
    localparam int SXYW = 49 + CW;
    localparam int MW   = 19 + CW;
    localparam logic [31:0]   DEPTH32 = 32'(HIST_DEPTH);
    localparam logic [63:0]   N64     = 64'(HIST_DEPTH);
    localparam logic [63:0]   N2_64   = 64'(2 * HIST_DEPTH);
    localparam logic [MW-1:0] N_MW    = MW'(HIST_DEPTH);
    localparam logic [AW-1:0] PTR_TOP = AW'(HIST_DEPTH - 1);

    // Configuration registers
    logic [16:0] acc_min_reg;
    logic [16:0] acc_max_reg;
    logic [31:0] max_dev_reg;
    logic        max_dev_en_reg;
    logic [19:0] min_trials_reg;

    // Tuning state
    logic [19:0]   trial_reg;
    logic [19:0]   accept_reg;
    logic [31:0]   rec_cnt_reg;
    logic [AW-1:0] wptr_reg;
    logic [31:0]   dev_reg;
    logic [31:0]   last_dev_reg;
    logic          last_vld_reg;
    logic [16:0]   rate_reg;
    logic [15:0]   r_reg;

    // History ring and fit pipeline
    logic [16:0]     hist_rate_mem [HIST_DEPTH];
    logic [31:0]     hist_dev_mem  [HIST_DEPTH];
    logic [16:0]     rd_rate_reg;
    logic [31:0]     rd_dev_reg;
    logic            rd_vld_reg;
    logic            prd_vld_reg;
    logic [16:0]     x_reg;
    logic [31:0]     y_reg;
    logic [33:0]     xx_reg;
    logic [48:0]     xy_reg;
    logic [SXW-1:0]  sx_reg;
    logic [SYW-1:0]  sy_reg;
    logic [SXXW-1:0] sxx_reg;
    logic [SXYW-1:0] sxy_reg;

    // Fit products
    logic [63:0]  nsxx_reg;
    logic [63:0]  sx2_reg;
    logic [63:0]  den_reg;
    logic [127:0] nsxy_reg;
    logic [127:0] sxsy_reg;
    logic [127:0] t1_reg;
    logic [127:0] t2_reg;
    mop_t         op_reg;
    logic         div_fit_reg;

    // Output word
    logic [31:0] out_dev_reg;
    logic [16:0] out_rate_reg;
    logic [2:0]  out_code_reg;

    // Unit connections
    logic [127:0] mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [127:0] mul_p;
    logic [127:0] div_n;
    logic [63:0]  div_d;
    logic         div_done;
    logic [31:0]  div_q;

    // Derived values
    logic          do_rec;
    logic [31:0]   rec_after;
    logic [63:0]   d_val;
    logic [MW-1:0] m_pos;
    logic [MW-1:0] m_two;
    logic          m_neg;
    logic [MW-1:0] m_mag;
    logic          n_neg;
    logic [127:0]  n_mag;
    logic          t_neg;
    logic [127:0]  num;
    logic          below;
    logic [32:0]   blind_sh;
    logic [31:0]   blind_dev;

    function automatic logic [31:0] clamp_dev(input logic [31:0] d, input logic en,
                                              input logic [31:0] lim);
        logic [31:0] res;
        res = d;
        if (en && (d > lim))
        begin
            res = lim;
        end
        return res;
    endfunction

    // A pair is recorded only when the deviation has moved since the last record
    assign do_rec    = !last_vld_reg || (last_dev_reg != dev_reg);
    assign rec_after = (do_rec && (rec_cnt_reg != 32'hFFFF_FFFF)) ? rec_cnt_reg + 32'd1
                                                                   : rec_cnt_reg;

    // Fit denominator
    assign d_val = (nsxx_reg > sx2_reg) ? nsxx_reg - sx2_reg : 64'd0;

    // n*(acc_min+acc_max) - 2*Sx in sign and magnitude
    assign m_pos = N_MW * MW'({1'b0, acc_min_reg} + {1'b0, acc_max_reg});
    assign m_two = MW'({sx_reg, 1'b0});
    assign m_neg = m_two > m_pos;
    assign m_mag = m_neg ? m_two - m_pos : m_pos - m_two;

    // n*Sxy - Sx*Sy in sign and magnitude
    assign n_neg = sxsy_reg > nsxy_reg;
    assign n_mag = n_neg ? sxsy_reg - nsxy_reg : nsxy_reg - sxsy_reg;

    // Numerator of the fitted value
    assign t_neg = n_neg ^ m_neg;
    always_comb
    begin
        if (!t_neg)
        begin
            num = t1_reg + t2_reg;
        end
        else if (t1_reg >= t2_reg)
        begin
            num = t1_reg - t2_reg;
        end
        else
        begin
            num = t2_reg - t1_reg;
        end
    end

    // Blind rescale from the multiplier product dev*(1+r)
    assign below     = {rate_reg, 1'b0} < ({1'b0, acc_min_reg} + {1'b0, acc_max_reg});
    assign blind_sh  = below ? mul_p[49:17] : mul_p[48:16];
    assign blind_dev = clamp_dev(blind_sh[32] ? 32'hFFFF_FFFF : blind_sh[31:0],
                                 max_dev_en_reg, max_dev_reg);

    // Multiplier operand selection
    always_comb
    begin
        mul_a = 128'd0;
        mul_b = 64'd0;
        case (cmd.mul_op)
            MOP_BLIND:
            begin
                mul_a = 128'(dev_reg);
                mul_b = 64'({1'b1, r_reg});
            end
            MOP_NSXX:
            begin
                mul_a = 128'(sxx_reg);
                mul_b = N64;
            end
            MOP_SX2:
            begin
                mul_a = 128'(sx_reg);
                mul_b = 64'(sx_reg);
            end
            MOP_DEN:
            begin
                mul_a = 128'(d_val);
                mul_b = N2_64;
            end
            MOP_NSXY:
            begin
                mul_a = 128'(sxy_reg);
                mul_b = N64;
            end
            MOP_SXSY:
            begin
                mul_a = 128'(sy_reg);
                mul_b = 64'(sx_reg);
            end
            MOP_T1:
            begin
                mul_a = 128'(sy_reg);
                mul_b = d_val;
            end
            MOP_T2:
            begin
                mul_a = n_mag;
                mul_b = 64'(m_mag);
            end
            default:
            begin
                mul_a = 128'd0;
                mul_b = 64'd0;
            end
        endcase
    end

    // Divider operands: acceptance rate or fitted value
    assign div_n = cmd.div_fit ? num : 128'({accept_reg, 16'd0});
    assign div_d = cmd.div_fit ? den_reg : 64'(trial_reg);

    mssa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    mssa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .q        (div_q)
    );

    // Status to the controller
    assign sts.few        = trial_reg < min_trials_reg;
    assign sts.trial_zero = trial_reg == 20'd0;
    assign sts.div_done   = div_done;
    assign sts.mul_done   = mul_done;
    assign sts.inwin      = (rate_reg >= acc_min_reg) && (rate_reg <= acc_max_reg);
    assign sts.fit_due    = rec_after > DEPTH32;
    assign sts.d_zero     = d_val == 64'd0;
    assign sts.num_neg    = t_neg && (t2_reg > t1_reg);

    // Control state, configuration and deviation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_min_reg    <= ACC_MIN_RST;
            acc_max_reg    <= ACC_MAX_RST;
            max_dev_reg    <= MAX_DEV_RST;
            max_dev_en_reg <= 1'b0;
            min_trials_reg <= MIN_TRIALS_RST;
            trial_reg      <= 20'd0;
            accept_reg     <= 20'd0;
            rec_cnt_reg    <= 32'd0;
            wptr_reg       <= '0;
            dev_reg        <= INIT_DEV_RST;
            last_dev_reg   <= 32'd0;
            last_vld_reg   <= 1'b0;
            rate_reg       <= 17'd0;
            rd_vld_reg     <= 1'b0;
            prd_vld_reg    <= 1'b0;
            op_reg         <= MOP_BLIND;
            div_fit_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.rd_en;
            prd_vld_reg <= rd_vld_reg;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACC_MIN:    acc_min_reg    <= cfg_data[16:0];
                    CFG_ACC_MAX:    acc_max_reg    <= cfg_data[16:0];
                    CFG_MAX_DEV:    max_dev_reg    <= cfg_data;
                    CFG_MAX_DEV_EN: max_dev_en_reg <= cfg_data[0];
                    CFG_INIT_DEV:   dev_reg        <= cfg_data;
                    CFG_MIN_TRIALS: min_trials_reg <= cfg_data[19:0];
                    default:
                    begin
                    end
                endcase
            end

            // Trial counting with saturation
            if (cmd.trial_upd)
            begin
                if (trial_reg != 20'hFFFFF)
                begin
                    trial_reg <= trial_reg + 20'd1;
                end
                if (accepted && (accept_reg != 20'hFFFFF))
                begin
                    accept_reg <= accept_reg + 20'd1;
                end
            end

            if (cmd.rate_zero)
            begin
                rate_reg <= 17'd0;
            end

            if (cmd.div_start)
            begin
                div_fit_reg <= cmd.div_fit;
            end

            // Update: clear counters and record the pair
            if (cmd.rec)
            begin
                trial_reg    <= 20'd0;
                accept_reg   <= 20'd0;
                last_dev_reg <= dev_reg;
                last_vld_reg <= 1'b1;
                rec_cnt_reg  <= rec_after;
                if (do_rec && (rec_cnt_reg != 32'hFFFF_FFFF))
                begin
                    wptr_reg <= (wptr_reg == PTR_TOP) ? '0 : wptr_reg + AW'(1);
                end
            end

            if (cmd.mul_start)
            begin
                op_reg <= cmd.mul_op;
            end

            // Divider results
            if (div_done)
            begin
                if (div_fit_reg)
                begin
                    dev_reg <= clamp_dev(div_q, max_dev_en_reg, max_dev_reg);
                end
                else
                begin
                    rate_reg <= div_q[16:0];
                end
            end

            if (mul_done && (op_reg == MOP_BLIND))
            begin
                dev_reg <= blind_dev;
            end
        end
    end

    // History ring, written at update and read during the fit sums
    always_ff @(posedge clk)
    begin
        if (cmd.rec && do_rec)
        begin
            hist_rate_mem[wptr_reg] <= rate_reg;
            hist_dev_mem[wptr_reg]  <= dev_reg;
        end
        if (cmd.rd_en)
        begin
            rd_rate_reg <= hist_rate_mem[rd_addr];
            rd_dev_reg  <= hist_dev_mem[rd_addr];
        end
    end

    // Fit sums: products registered, then accumulated
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            x_reg  <= rd_rate_reg;
            y_reg  <= rd_dev_reg;
            xx_reg <= rd_rate_reg * rd_rate_reg;
            xy_reg <= rd_rate_reg * rd_dev_reg;
        end
        if (cmd.sum_clr)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
        end
        else if (prd_vld_reg)
        begin
            sx_reg  <= sx_reg + SXW'(x_reg);
            sy_reg  <= sy_reg + SYW'(y_reg);
            sxx_reg <= sxx_reg + SXXW'(xx_reg);
            sxy_reg <= sxy_reg + SXYW'(xy_reg);
        end
    end

    // Capture of multiplier results by operation
    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (op_reg)
                MOP_NSXX: nsxx_reg <= mul_p[63:0];
                MOP_SX2:  sx2_reg  <= mul_p[63:0];
                MOP_DEN:  den_reg  <= mul_p[63:0];
                MOP_NSXY: nsxy_reg <= mul_p;
                MOP_SXSY: sxsy_reg <= mul_p;
                MOP_T1:   t1_reg   <= {mul_p[126:0], 1'b0};
                MOP_T2:   t2_reg   <= mul_p;
                default:
                begin
                end
            endcase
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.r_load)
        begin
            r_reg <= random_fraction;
        end
        if (cmd.out_load)
        begin
            out_dev_reg  <= dev_reg;
            out_rate_reg <= (cmd.out_code >= OUT_KEPT) ? rate_reg : 17'd0;
            out_code_reg <= cmd.out_code;
        end
    end

    assign current_dev = out_dev_reg;
    assign acc_rate    = out_rate_reg;
    assign outcome     = out_code_reg;

endmodule

@@ hdl/mssa_ctrl.sv @@
// Controller: sequences trial counting, rate division, recording and the fit.
module mssa_ctrl
    import mssa_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int AW = $clog2(HIST_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          req_type,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          cfg_ready,
    input  sts_t          sts,
    output cmd_t          cmd,
    output logic [AW-1:0] rd_addr
);

    localparam int IW = $clog2(HIST_DEPTH + 2);
    localparam logic [IW-1:0] IDX_N    = IW'(HIST_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(HIST_DEPTH + 1);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_RATE  = 17'h00002,
        S_REC   = 17'h00004,
        S_BLIND = 17'h00008,
        S_SUM   = 17'h00010,
        S_FIT0  = 17'h00020,
        S_NSXX  = 17'h00040,
        S_SX2   = 17'h00080,
        S_CHKD  = 17'h00100,
        S_DEN   = 17'h00200,
        S_NSXY  = 17'h00400,
        S_SXSY  = 17'h00800,
        S_T1    = 17'h01000,
        S_T2    = 17'h02000,
        S_CHKN  = 17'h04000,
        S_DIVW  = 17'h08000,
        S_FIN   = 17'h10000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [2:0]    outc_reg;
    logic [2:0]    outc_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          out_vld_reg;
    logic          out_vld_next;
    logic          slot_free;

    // The output register frees up when empty or when its word is taken
    assign slot_free = !out_vld_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign cfg_ready = state_reg == S_IDLE;
    assign out_valid = out_vld_reg;
    assign rd_addr   = idx_reg[AW-1:0];

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        outc_next    = outc_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.mul_op   = MOP_BLIND;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.r_load = 1'b1;
                    if (!req_type)
                    begin
                        cmd.trial_upd = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_code  = OUT_TRIAL;
                    end
                    else if (sts.few)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_code = OUT_FEW;
                    end
                    else if (sts.trial_zero)
                    begin
                        cmd.rate_zero = 1'b1;
                        state_next    = S_REC;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_RATE;
                    end
                end
            end
            S_RATE:
            begin
                if (sts.div_done)
                begin
                    state_next = S_REC;
                end
            end
            S_REC:
            begin
                cmd.rec = 1'b1;
                if (!sts.inwin)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_BLIND;
                    outc_next     = OUT_BLIND;
                    state_next    = S_BLIND;
                end
                else if (sts.fit_due)
                begin
                    cmd.sum_clr = 1'b1;
                    idx_next    = '0;
                    state_next  = S_SUM;
                end
                else
                begin
                    outc_next  = OUT_KEPT;
                    state_next = S_FIN;
                end
            end
            S_BLIND:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_SUM:
            begin
                cmd.rd_en = idx_reg < IDX_N;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FIT0;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_FIT0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_NSXX;
                state_next    = S_NSXX;
            end
            S_NSXX:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_SX2;
                    state_next    = S_SX2;
                end
            end
            S_SX2:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_CHKD;
                end
            end
            S_CHKD:
            begin
                cmd.mul_start = 1'b1;
                if (sts.d_zero)
                begin
                    cmd.mul_op = MOP_BLIND;
                    outc_next  = OUT_FITBL;
                    state_next = S_BLIND;
                end
                else
                begin
                    cmd.mul_op = MOP_DEN;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_NSXY;
                    state_next    = S_NSXY;
                end
            end
            S_NSXY:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_SXSY;
                    state_next    = S_SXSY;
                end
            end
            S_SXSY:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_T1;
                    state_next    = S_T1;
                end
            end
            S_T1:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_T2;
                    state_next    = S_T2;
                end
            end
            S_T2:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_CHKN;
                end
            end
            S_CHKN:
            begin
                if (sts.num_neg)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MOP_BLIND;
                    outc_next     = OUT_FITBL;
                    state_next    = S_BLIND;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_fit   = 1'b1;
                    outc_next     = OUT_FIT;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = outc_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            outc_reg    <= OUT_TRIAL;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            outc_reg    <= outc_next;
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

@@ hdl/mcmc_step_size_autotuner.sv @@
// Top level of the MCMC proposal step-size autotuner.
//
// Input channel (in_valid/in_ready): one word per sampler step. A trial word
// (req_type 0) counts a try and, if accepted is set, an accept. An update word
// (req_type 1) retunes the Q16.16 deviation from the Q1.16 acceptance rate.
// Output channel (out_valid/out_ready): exactly one result word per input word,
// carrying the deviation after the word, the rate of an acting update and the
// outcome code. Configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes the tuning registers while the block is idle.
// A trial word, or an update with too few tries, loads its result word as it is
// taken, so trials stream at one per cycle while the receiver takes each result.
// An acting update runs the serial rate division, unless no tries were counted,
// and records; a blind rescale then adds a serial multiply. A fit adds the
// history sums and up to seven serial multiplies, then another division, or a
// blind rescale when the denominator is zero or the numerator is negative.
// The result word is then loaded once the output register is free.
// Reset clears counters and history bookkeeping and loads register defaults.
// A stalled receiver holds the result word; the block then takes no new word.
module mcmc_step_size_autotuner
    import mssa_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic        accepted,
    input  logic [15:0] random_fraction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] current_dev,
    output logic [16:0] acc_rate,
    output logic [2:0]  outcome,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(HIST_DEPTH);

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] rd_addr;
    logic          cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    mssa_ctrl #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    mssa_dp #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .sts             (sts),
        .accepted        (accepted),
        .random_fraction (random_fraction),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .current_dev     (current_dev),
        .acc_rate        (acc_rate),
        .outcome         (outcome)
    );

    // A trial word is answered in the very next cycle
    a_trial_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !req_type |=> out_valid && (outcome == OUT_TRIAL))
        else $error("trial word not answered in the next cycle");

    // Words that do not compute a rate report a zero rate
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((outcome == OUT_TRIAL) || (outcome == OUT_FEW)) |-> acc_rate == 17'd0)
        else $error("rate reported for a word that computes none");

    // No new word is taken while a result word is held back
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the result word is stalled");

endmodule
